// ===== hw/rtl/spk_pkg.sv =====
// Shared types, constants and round functions of the Speck128 cipher.
`default_nettype none

package spk_pkg;

   localparam int WORD_W      = 64;
   localparam int NUM_CELLS   = 34;          // round key cells, one per round at most
   localparam int CELL_IDX_W  = 6;
   localparam int ROT_A       = 8;
   localparam int ROT_B       = 3;

   localparam logic [CELL_IDX_W-1:0] LAST_CELL   = CELL_IDX_W'(NUM_CELLS - 1);
   localparam logic [CELL_IDX_W-1:0] BASE_ROUNDS = CELL_IDX_W'(32);

   // configuration register indexes
   localparam logic [2:0] CSR_KEY_SIZE   = 3'd0;
   localparam logic [2:0] CSR_KEY_WORD_0 = 3'd1;
   localparam logic [2:0] CSR_KEY_WORD_1 = 3'd2;
   localparam logic [2:0] CSR_KEY_WORD_2 = 3'd3;
   localparam logic [2:0] CSR_KEY_WORD_3 = 3'd4;

   // key size codes
   localparam logic [1:0] KEY_128 = 2'd0;
   localparam logic [1:0] KEY_192 = 2'd1;
   localparam logic [1:0] KEY_256 = 2'd2;

   // commands
   localparam logic CMD_ENCRYPT = 1'b0;
   localparam logic CMD_DECRYPT = 1'b1;

   typedef logic [WORD_W-1:0] word_type;

   typedef struct packed {
      word_type x;
      word_type y;
   } word_pair_type;

   typedef struct packed {
      logic shift;       // move keys one cell this cycle
      logic dir_right;   // 1: take from left neighbor, 0: from right neighbor
   } cell_ctrl_type;

   function automatic word_type ror_a(input word_type v);
      return {v[ROT_A-1:0], v[WORD_W-1:ROT_A]};
   endfunction

   function automatic word_type rol_a(input word_type v);
      return {v[WORD_W-ROT_A-1:0], v[WORD_W-1:WORD_W-ROT_A]};
   endfunction

   function automatic word_type ror_b(input word_type v);
      return {v[ROT_B-1:0], v[WORD_W-1:ROT_B]};
   endfunction

   function automatic word_type rol_b(input word_type v);
      return {v[WORD_W-ROT_B-1:0], v[WORD_W-1:WORD_W-ROT_B]};
   endfunction

   // x = (ror8(x) + y) ^ k ; y = rol3(y) ^ x
   function automatic word_pair_type speck_fwd(input word_type x, input word_type y,
                                               input word_type k);
      word_pair_type r;
      r.x = (ror_a(x) + y) ^ k;
      r.y = rol_b(y) ^ r.x;
      return r;
   endfunction

   // y = ror3(y ^ x) ; x = rol8((x ^ k) - y)
   function automatic word_pair_type speck_inv(input word_type x, input word_type y,
                                               input word_type k);
      word_pair_type r;
      r.y = ror_b(y ^ x);
      r.x = rol_a((x ^ k) - r.y);
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/spk_key_cell.sv =====
// One cell of the round key ring: holds a round key, passes it to a neighbor.
`default_nettype none

module spk_key_cell (
   input  wire                   clock,
   input  spk_pkg::cell_ctrl_type ctrl,
   input  spk_pkg::word_type      from_left,
   input  spk_pkg::word_type      from_right,
   output spk_pkg::word_type      key
);
   import spk_pkg::*;

   word_type key_ff;
   word_type key_in;

   always_comb begin
      key_in = key_ff;
      if (ctrl.shift) begin
         key_in = ctrl.dir_right ? from_left : from_right;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   assign key = key_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/spk_round_unit.sv =====
// Block state registers and the forward / inverse Speck round.
`default_nettype none

module spk_round_unit (
   input  wire               clock,
   input  wire               load,
   input  spk_pkg::word_type load_x,
   input  spk_pkg::word_type load_y,
   input  wire               step,
   input  wire               decrypt,
   input  spk_pkg::word_type key,
   output spk_pkg::word_type x,
   output spk_pkg::word_type y
);
   import spk_pkg::*;

   word_type      x_ff, y_ff;
   word_type      x_in, y_in;
   word_pair_type fwd, inv;

   always_comb begin
      fwd  = speck_fwd(x_ff, y_ff, key);
      inv  = speck_inv(x_ff, y_ff, key);
      x_in = x_ff;
      y_in = y_ff;
      if (load) begin
         x_in = load_x;
         y_in = load_y;
      end else if (step) begin
         x_in = decrypt ? inv.x : fwd.x;
         y_in = decrypt ? inv.y : fwd.y;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
   end

   assign x = x_ff;
   assign y = y_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/speck128_block_cipher.sv =====
// Top level of the Speck128 cipher: key schedule, round key ring and control.
`default_nettype none

// Speck128 encrypt/decrypt engine for 128-, 192- and 256-bit keys.
// After reset, and after every write to a key register, the key schedule
// runs (a load step, then the expansion steps that fill the ring) and busy
// stays high; a block is accepted at a rising edge with start high and busy
// low. Round keys live in a ring of 34 cells that rotates one cell per cycle,
// left for encryption, right for decryption, so the round unit always sees
// the next key at a fixed end of the ring. A block runs one round step per
// ring cell whatever the key size (rounds past 32 + key size are skipped, the
// ring still turns a full lap and ends where it started); the result appears
// on rsp_result_high / rsp_result_low with rsp_valid high for exactly one
// cycle. The receiver cannot stall that beat. busy drops in the same cycle as
// the strobe, so the next block can be taken while the strobe is high.
// csr_ready is low while a block runs. A register write that hits a key
// register restarts the schedule; busy is also high in the cycle such a write
// is offered, so no block is taken beside it. Write indexes beyond the key
// words are ignored, and key size 3 acts as a 256-bit key.

module speck128_block_cipher (
   input  wire                clock,
   input  wire                reset,
   // block request
   input  wire                start,
   output logic               busy,
   input  wire                req_command,
   input  spk_pkg::word_type  req_block_high,
   input  spk_pkg::word_type  req_block_low,
   // block result
   output logic               rsp_valid,
   output spk_pkg::word_type  rsp_result_high,
   output spk_pkg::word_type  rsp_result_low,
   // configuration
   input  wire                csr_valid,
   output logic               csr_ready,
   input  wire [2:0]          csr_index,
   input  spk_pkg::word_type  csr_data
);
   import spk_pkg::*;

   typedef enum logic [3:0] {
      ST_LOAD   = 4'b0001,   // take key words into the schedule registers
      ST_EXPAND = 4'b0010,   // shift 34 schedule outputs into the ring
      ST_IDLE   = 4'b0100,
      ST_RUN    = 4'b1000    // one round per cycle
   } state_type;

   state_type state_ff, state_in;

   // configuration registers
   logic [1:0] key_size_ff, key_size_in;
   word_type   key_word_ff [4];
   word_type   key_word_in [4];
   logic       csr_hit;

   // key schedule registers
   word_type   sk_ff, sk_in;
   word_type   sl_ff [3];
   word_type   sl_in [3];
   word_pair_type sched;

   // shared step counter / key index
   logic [CELL_IDX_W-1:0] idx_ff, idx_in;
   logic                  decrypt_ff, decrypt_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic [1:0]            m;       // key words beyond two
   logic [CELL_IDX_W-1:0] rounds;

   logic                  accept;
   logic                  last_step;
   logic                  round_on;

   cell_ctrl_type         cell_ctrl;
   word_type              ring [NUM_CELLS];
   word_type              ring_fill;
   word_type              round_key;
   word_type              x, y;

   assign m      = (key_size_ff == 2'd3) ? KEY_256 : key_size_ff;
   assign rounds = BASE_ROUNDS + CELL_IDX_W'(m);

   // key registers only move while no block is in flight
   assign csr_ready = (state_ff != ST_RUN);
   assign csr_hit   = csr_valid && csr_ready &&
                      (csr_index inside {CSR_KEY_SIZE, CSR_KEY_WORD_0, CSR_KEY_WORD_1,
                                         CSR_KEY_WORD_2, CSR_KEY_WORD_3});

   // a key write wins over a block offered in the same cycle
   assign busy   = (state_ff != ST_IDLE) || csr_hit;
   assign accept = start && (state_ff == ST_IDLE) && !csr_hit;

   // ---- configuration registers ----
   always_comb begin
      key_size_in = key_size_ff;
      for (int i = 0; i < 4; i++) begin
         key_word_in[i] = key_word_ff[i];
      end
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_KEY_SIZE:   key_size_in    = csr_data[1:0];
            CSR_KEY_WORD_0: key_word_in[0] = csr_data;
            CSR_KEY_WORD_1: key_word_in[1] = csr_data;
            CSR_KEY_WORD_2: key_word_in[2] = csr_data;
            CSR_KEY_WORD_3: key_word_in[3] = csr_data;
            default:        ;  // out of range: dropped
         endcase
      end
   end

   // ---- key schedule ----
   // sl_ff[0] is the key word next to k; the active ones rotate after each round
   assign sched = speck_fwd(sl_ff[0], sk_ff, WORD_W'(idx_ff));

   always_comb begin
      sk_in = sk_ff;
      for (int i = 0; i < 3; i++) begin
         sl_in[i] = sl_ff[i];
      end
      if (state_ff == ST_LOAD) begin
         case (m)
            KEY_128: begin
               sk_in    = key_word_ff[1];
               sl_in[0] = key_word_ff[0];
            end
            KEY_192: begin
               sk_in    = key_word_ff[2];
               sl_in[0] = key_word_ff[1];
               sl_in[1] = key_word_ff[0];
            end
            default: begin
               sk_in    = key_word_ff[3];
               sl_in[0] = key_word_ff[2];
               sl_in[1] = key_word_ff[1];
               sl_in[2] = key_word_ff[0];
            end
         endcase
      end else if (state_ff == ST_EXPAND) begin
         sk_in = sched.y;
         case (m)
            KEY_128: begin
               sl_in[0] = sched.x;
            end
            KEY_192: begin
               sl_in[0] = sl_ff[1];
               sl_in[1] = sched.x;
            end
            default: begin
               sl_in[0] = sl_ff[1];
               sl_in[1] = sl_ff[2];
               sl_in[2] = sched.x;
            end
         endcase
      end
   end

   // ---- control ----
   assign last_step = decrypt_ff ? (idx_ff == '0) : (idx_ff == LAST_CELL);
   assign round_on  = (state_ff == ST_RUN) && (idx_ff < rounds);

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      decrypt_in   = decrypt_ff;
      rsp_valid_in = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            idx_in   = '0;
            state_in = ST_EXPAND;
         end
         ST_EXPAND: begin
            idx_in = idx_ff + 1'b1;
            if (idx_ff == LAST_CELL) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               decrypt_in = (req_command == CMD_DECRYPT);
               idx_in     = (req_command == CMD_DECRYPT) ? LAST_CELL : '0;
               state_in   = ST_RUN;
            end
         end
         ST_RUN: begin
            idx_in = decrypt_ff ? idx_ff - 1'b1 : idx_ff + 1'b1;
            if (last_step) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
      // a key change restarts the schedule
      if (csr_hit) begin
         state_in = ST_LOAD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         key_size_ff  <= KEY_128;
         for (int i = 0; i < 4; i++) begin
            key_word_ff[i] <= '0;
         end
         idx_ff       <= '0;
         decrypt_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         key_size_ff  <= key_size_in;
         for (int i = 0; i < 4; i++) begin
            key_word_ff[i] <= key_word_in[i];
         end
         idx_ff       <= idx_in;
         decrypt_ff   <= decrypt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sk_ff <= sk_in;
      for (int i = 0; i < 3; i++) begin
         sl_ff[i] <= sl_in[i];
      end
   end

   // ---- round key ring ----
   always_comb begin
      cell_ctrl.shift     = (state_ff == ST_EXPAND) || (state_ff == ST_RUN);
      cell_ctrl.dir_right = (state_ff == ST_RUN) && decrypt_ff;
   end

   // during expansion new keys enter at the last cell; otherwise the ring closes
   assign ring_fill = (state_ff == ST_EXPAND) ? sk_ff : ring[0];

   for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
      word_type left_nb;
      word_type right_nb;
      if (c == 0) begin : g_first
         assign left_nb = ring[NUM_CELLS-1];
      end else begin : g_mid_l
         assign left_nb = ring[c-1];
      end
      if (c == NUM_CELLS - 1) begin : g_last
         assign right_nb = ring_fill;
      end else begin : g_mid_r
         assign right_nb = ring[c+1];
      end
      spk_key_cell u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl),
         .from_left  (left_nb),
         .from_right (right_nb),
         .key        (ring[c])
      );
   end

   // encryption walks keys up from cell 0, decryption walks down from the last cell
   assign round_key = decrypt_ff ? ring[NUM_CELLS-1] : ring[0];

   spk_round_unit u_round (
      .clock   (clock),
      .load    (accept),
      .load_x  (req_block_high),
      .load_y  (req_block_low),
      .step    (round_on),
      .decrypt (decrypt_ff),
      .key     (round_key),
      .x       (x),
      .y       (y)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_high = x;
   assign rsp_result_low  = y;

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the Speck128 encrypt/decrypt engine.
module tb_top;
   import spk_pkg::*;

   localparam int CLK_HALF     = 4;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int DRAIN_CYCLES = 40;     // a little over one block period
   localparam int PHASES       = 8;
   localparam int PHASE_BLOCKS = 232;    // 8 x 232 random blocks
   localparam int MAX_REPORTS  = 50;     // keep the log short on a broken build
   localparam int MAX_GAP      = 45;     // longest sender gap, spans a whole block

   // register indexes past the key words: writes there must be dropped
   localparam logic [2:0] CSR_SPARE_A = 3'd5;
   localparam logic [2:0] CSR_SPARE_B = 3'd6;
   localparam logic [2:0] CSR_SPARE_C = 3'd7;

   // key size 3 is not a real size, the engine treats it as 256 bits
   localparam logic [1:0] KEY_SIZE_ALIAS = 2'd3;

   localparam word_type ALL_ONES = {WORD_W{1'b1}};

   // published Speck128/128 vector: key (l0, k0), plaintext and ciphertext as (x, y)
   localparam word_type PAPER_KEY_HI = 64'h0f0e0d0c0b0a0908;
   localparam word_type PAPER_KEY_LO = 64'h0706050403020100;
   localparam word_type PAPER_PT_HI  = 64'h6c61766975716520;
   localparam word_type PAPER_PT_LO  = 64'h7469206564616d20;
   localparam word_type PAPER_CT_HI  = 64'ha65d985179783265;
   localparam word_type PAPER_CT_LO  = 64'h7860fedf5c570d18;

   typedef enum logic {ROW_CSR, ROW_BLOCK} row_kind_type;

   // one line of the directed plan: either a register write or a block
   typedef struct packed {
      row_kind_type kind;
      logic [2:0]   index;
      word_type     data;
      logic         cmd;
      word_type     hi;
      word_type     lo;
      logic         known;     // expected block typed in below
      word_type     known_hi;
      word_type     known_lo;
   } plan_row_type;

   typedef struct packed {
      word_type    hi;
      word_type    lo;
      logic [31:0] seq;
   } expected_block_type;

   logic      clock = 1'b0;
   logic      reset = 1'b1;

   logic      start          = 1'b0;
   logic      busy;
   logic      req_command    = CMD_ENCRYPT;
   word_type  req_block_high = '0;
   word_type  req_block_low  = '0;

   logic      rsp_valid;
   word_type  rsp_result_high;
   word_type  rsp_result_low;

   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [2:0] csr_index = CSR_KEY_SIZE;
   word_type   csr_data  = '0;

   // shadow of the configuration and the round keys it expands to
   logic [1:0] key_size_reg;
   word_type   key_regs [4];
   word_type   round_keys [NUM_CELLS];
   int         round_total;

   expected_block_type expected_blocks [$];
   plan_row_type       plan [$];

   int unsigned cycle_count    = 0;
   int unsigned mismatch_count = 0;
   int unsigned blocks_sent    = 0;

   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   speck128_block_cipher uut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_command     (req_command),
      .req_block_high  (req_block_high),
      .req_block_low   (req_block_low),
      .rsp_valid       (rsp_valid),
      .rsp_result_high (rsp_result_high),
      .rsp_result_low  (rsp_result_low),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   // ---------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------
   function automatic word_type rotr(input word_type v, input int n);
      return (v >> n) | (v << (WORD_W - n));
   endfunction

   function automatic word_type rotl(input word_type v, input int n);
      return (v << n) | (v >> (WORD_W - n));
   endfunction

   // Expand the shadowed key into round_keys. The key schedule reuses the
   // round function with the round number as key; the l words rotate
   // through one slot per round.
   function automatic void expand_round_keys();
      int       extra;
      int       nwords;
      int       slot;
      word_type k;
      word_type l [3];
      extra  = (key_size_reg == KEY_SIZE_ALIAS) ? 2 : int'(key_size_reg);
      nwords = extra + 2;
      round_total = 32 + extra;
      k = key_regs[nwords - 1];
      for (int i = 0; i < nwords - 1; i++)
         l[i] = key_regs[nwords - 2 - i];
      for (int i = 0; i < NUM_CELLS; i++)
         round_keys[i] = '0;
      round_keys[0] = k;
      for (int i = 0; i + 1 < round_total; i++) begin
         slot    = i % (nwords - 1);
         l[slot] = (rotr(l[slot], ROT_A) + k) ^ word_type'(i);
         k       = rotl(k, ROT_B) ^ l[slot];
         round_keys[i + 1] = k;
      end
   endfunction

   function automatic expected_block_type speck_predict(input logic cmd, input word_type hi,
                                                        input word_type lo);
      expected_block_type r;
      word_type x;
      word_type y;
      x = hi;
      y = lo;
      if (cmd == CMD_ENCRYPT) begin
         for (int i = 0; i < round_total; i++) begin
            x = (rotr(x, ROT_A) + y) ^ round_keys[i];
            y = rotl(y, ROT_B) ^ x;
         end
      end else begin
         for (int i = round_total - 1; i >= 0; i--) begin
            y = rotr(y ^ x, ROT_B);
            x = rotl((x ^ round_keys[i]) - y, ROT_A);
         end
      end
      r.hi  = x;
      r.lo  = y;
      r.seq = '0;
      return r;
   endfunction

   // ---------------------------------------------------------------
   // Reporting and result checking
   // ---------------------------------------------------------------
   task automatic report_mismatch(input string msg);
      if (mismatch_count < MAX_REPORTS)
         $display("[%0d] MISMATCH: %s", cycle_count, msg);
      mismatch_count++;
   endtask

   // The strobe lasts one cycle and cannot be held off, so every edge with
   // rsp_valid high is a beat to check against the oldest pending block.
   always @(posedge clock) begin
      expected_block_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (expected_blocks.size() == 0) begin
            report_mismatch($sformatf("result %h_%h with no block pending",
                                      rsp_result_high, rsp_result_low));
         end else begin
            want = expected_blocks.pop_front();
            if (rsp_result_high !== want.hi)
               report_mismatch($sformatf("block %0d result_high %h, want %h",
                                         want.seq, rsp_result_high, want.hi));
            if (rsp_result_low !== want.lo)
               report_mismatch($sformatf("block %0d result_low %h, want %h",
                                         want.seq, rsp_result_low, want.lo));
         end
      end
   end

   // hard stop in case the engine hangs or drops a result
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------
   // Neither task lowers its valid after the beat: the caller either
   // follows with another beat in the same step or drops it itself.

   // register write; the shadow follows at the accepting edge
   task automatic write_reg(input logic [2:0] idx, input word_type data);
      start     <= 1'b0;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      case (idx)
         CSR_KEY_SIZE:   key_size_reg = data[1:0];
         CSR_KEY_WORD_0: key_regs[0]  = data;
         CSR_KEY_WORD_1: key_regs[1]  = data;
         CSR_KEY_WORD_2: key_regs[2]  = data;
         CSR_KEY_WORD_3: key_regs[3]  = data;
         default: ;
      endcase
      expand_round_keys();
   endtask

   // Offer one block and hold it until busy is low at an edge. The
   // expectation is queued at that same edge with the config then in force.
   task automatic send_block(input logic cmd, input word_type hi, input word_type lo,
                             input logic known, input word_type known_hi,
                             input word_type known_lo);
      expected_block_type want;
      csr_valid      <= 1'b0;
      start          <= 1'b1;
      req_command    <= cmd;
      req_block_high <= hi;
      req_block_low  <= lo;
      do @(posedge clock); while (busy !== 1'b0);
      want = speck_predict(cmd, hi, lo);
      if (known) begin
         want.hi = known_hi;
         want.lo = known_lo;
      end
      want.seq = blocks_sent;
      blocks_sent++;
      expected_blocks.push_back(want);
   endtask

   // wait until every block sent has come back; registers move only then
   task automatic settle();
      start <= 1'b0;
      while (expected_blocks.size() != 0)
         @(posedge clock);
   endtask

   function automatic word_type pick_word();
      int sel;
      sel = $urandom_range(15);
      if (sel == 0)
         return '0;
      else if (sel == 1)
         return ALL_ONES;
      else
         return {$urandom, $urandom};
   endfunction

   // ---------------------------------------------------------------
   // Directed plan
   // ---------------------------------------------------------------
   function automatic plan_row_type csr_row(input logic [2:0] idx, input word_type data);
      plan_row_type r;
      r       = '0;
      r.kind  = ROW_CSR;
      r.index = idx;
      r.data  = data;
      return r;
   endfunction

   function automatic plan_row_type block_row(input logic cmd, input word_type hi,
                                              input word_type lo);
      plan_row_type r;
      r      = '0;
      r.kind = ROW_BLOCK;
      r.cmd  = cmd;
      r.hi   = hi;
      r.lo   = lo;
      return r;
   endfunction

   function automatic plan_row_type known_row(input logic cmd, input word_type hi,
                                              input word_type lo, input word_type eh,
                                              input word_type el);
      plan_row_type r;
      r          = block_row(cmd, hi, lo);
      r.known    = 1'b1;
      r.known_hi = eh;
      r.known_lo = el;
      return r;
   endfunction

   // ---------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------
   initial begin
      word_type   key_data;
      logic [1:0] size_code;
      int         idle_pct;

      key_size_reg = KEY_128;
      for (int i = 0; i < 4; i++)
         key_regs[i] = '0;
      expand_round_keys();

      // schedule of the all-zero 128-bit key, straight out of reset
      plan.push_back(block_row(CMD_ENCRYPT, '0, '0));
      plan.push_back(block_row(CMD_ENCRYPT, ALL_ONES, ALL_ONES));
      plan.push_back(block_row(CMD_DECRYPT, ALL_ONES, '0));
      // size field keeps only its low two bits
      plan.push_back(csr_row(CSR_KEY_SIZE, {62'h3fff_ffff_ffff_ffff, KEY_128}));
      plan.push_back(csr_row(CSR_KEY_WORD_0, PAPER_KEY_HI));
      plan.push_back(csr_row(CSR_KEY_WORD_1, PAPER_KEY_LO));
      plan.push_back(known_row(CMD_ENCRYPT, PAPER_PT_HI, PAPER_PT_LO,
                               PAPER_CT_HI, PAPER_CT_LO));
      plan.push_back(known_row(CMD_DECRYPT, PAPER_CT_HI, PAPER_CT_LO,
                               PAPER_PT_HI, PAPER_PT_LO));
      // upper key words are dead for a 128-bit key, spare indexes do nothing
      plan.push_back(csr_row(CSR_KEY_WORD_2, ALL_ONES));
      plan.push_back(csr_row(CSR_KEY_WORD_3, ALL_ONES));
      plan.push_back(csr_row(CSR_SPARE_A, ALL_ONES));
      plan.push_back(csr_row(CSR_SPARE_B, '0));
      plan.push_back(csr_row(CSR_SPARE_C, ALL_ONES));
      plan.push_back(known_row(CMD_ENCRYPT, PAPER_PT_HI, PAPER_PT_LO,
                               PAPER_CT_HI, PAPER_CT_LO));
      // 192-bit key, 33 rounds
      plan.push_back(csr_row(CSR_KEY_SIZE, {62'h0, KEY_192}));
      plan.push_back(block_row(CMD_ENCRYPT, PAPER_PT_HI, PAPER_PT_LO));
      plan.push_back(block_row(CMD_DECRYPT, ALL_ONES, ALL_ONES));
      // 256-bit key, 34 rounds
      plan.push_back(csr_row(CSR_KEY_SIZE, {62'h0, KEY_256}));
      plan.push_back(csr_row(CSR_KEY_WORD_3, 64'h1f1e1d1c1b1a1918));
      plan.push_back(block_row(CMD_ENCRYPT, '0, ALL_ONES));
      plan.push_back(block_row(CMD_DECRYPT, PAPER_PT_HI, PAPER_PT_LO));
      // size code 3 aliases the 256-bit key
      plan.push_back(csr_row(CSR_KEY_SIZE, {62'h2000_0000_0000_0000, KEY_SIZE_ALIAS}));
      plan.push_back(block_row(CMD_ENCRYPT, '0, ALL_ONES));
      plan.push_back(block_row(CMD_DECRYPT, PAPER_PT_HI, PAPER_PT_LO));
      // all-ones key at full length
      plan.push_back(csr_row(CSR_KEY_WORD_0, ALL_ONES));
      plan.push_back(csr_row(CSR_KEY_WORD_1, ALL_ONES));
      plan.push_back(csr_row(CSR_KEY_WORD_3, ALL_ONES));
      plan.push_back(block_row(CMD_ENCRYPT, '0, '0));
      plan.push_back(block_row(CMD_ENCRYPT, ALL_ONES, ALL_ONES));
      plan.push_back(block_row(CMD_DECRYPT, '0, '0));
      // back to the reset key
      plan.push_back(csr_row(CSR_KEY_SIZE, '0));
      plan.push_back(csr_row(CSR_KEY_WORD_0, '0));
      plan.push_back(csr_row(CSR_KEY_WORD_1, '0));
      plan.push_back(block_row(CMD_ENCRYPT, '0, '0));

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // the engine expands the reset key first; send_block waits out busy
      foreach (plan[r]) begin
         if (plan[r].kind == ROW_CSR) begin
            settle();
            write_reg(plan[r].index, plan[r].data);
         end else begin
            send_block(plan[r].cmd, plan[r].hi, plan[r].lo, plan[r].known,
                       plan[r].known_hi, plan[r].known_lo);
         end
      end

      // Random phases: a fresh key per phase, cycling through every size
      // code; the last two phases use the all-ones and all-zero extremes.
      // Sender idling rotates between none, 58% and 33%.
      for (int p = 0; p < PHASES; p++) begin
         idle_pct  = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 58 : 33);
         size_code = 2'(p % 4);
         settle();
         key_data       = {$urandom, $urandom};
         key_data[1:0]  = size_code;
         write_reg(CSR_KEY_SIZE, key_data);
         for (int w = 0; w < 4; w++) begin
            if (p == PHASES - 2)
               key_data = ALL_ONES;
            else if (p == PHASES - 1)
               key_data = '0;
            else
               key_data = pick_word();
            write_reg(CSR_KEY_WORD_0 + 3'(w), key_data);
         end
         if ($urandom_range(1) == 1)
            write_reg(CSR_SPARE_A + 3'($urandom_range(2)), {$urandom, $urandom});

         for (int n = 0; n < PHASE_BLOCKS; n++) begin
            // a gap up to a whole block long lands on every point of a round
            if ($urandom_range(99) < idle_pct) begin
               start     <= 1'b0;
               csr_valid <= 1'b0;
               repeat ($urandom_range(1, MAX_GAP)) @(posedge clock);
            end
            send_block($urandom_range(1) ? CMD_DECRYPT : CMD_ENCRYPT,
                       pick_word(), pick_word(), 1'b0, '0, '0);
         end
      end

      settle();
      // catch any stray beat after the last expected one
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/spk_pkg.sv
hw/rtl/spk_key_cell.sv
hw/rtl/spk_round_unit.sv
hw/rtl/speck128_block_cipher.sv
dv/tb_top.sv
